[rtl/tdkc_pkg.sv]
// Shared constants, keyframe tables, sine helper and control types for the time-of-day core.
package tdkc_pkg;

  // Field widths
  localparam int TIME_W   = 24;   // signed Q7.16 hours
  localparam int HOUR_W   = 21;   // unsigned Q5.16 hours
  localparam int COLOR_W  = 16;   // Q0.16
  localparam int SUN_W    = 16;   // signed Q1.15
  localparam int FRAC_W   = 16;   // interpolation fraction bits
  localparam int ACC_W    = 25;   // signed accumulator for the wrap
  localparam int SINE_W   = 15;   // magnitude of a table entry

  // Time constants in Q5.16 hours
  localparam logic [HOUR_W-1:0] DAY_Q16     = 21'd1572864;  // 24h
  localparam logic [HOUR_W-1:0] SHIFT_Q16   = 21'd1179648;  // 18h
  localparam int                QUARTER_W   = 19;
  localparam logic [QUARTER_W-1:0] QUARTER_Q16 = 19'd393216; // 6h = 3 * 2^17
  localparam int                QUARTER_SHIFT = 17;
  localparam logic [14:0]       RECIP3      = 15'd21846;    // ceil(2^16/3)
  localparam int                RECIP3_SHIFT = 16;

  // Keyframes
  localparam int KF_MAX     = 16;
  localparam int KF_IDX_W   = 4;
  localparam int CHAN_COUNT = 6;  // sky r,g,b then ambient r,g,b
  localparam int CHAN_W     = 3;

  localparam int SINE_TABLE_DEPTH_DEF = 256;
  localparam int KEYFRAME_COUNT_DEF   = 6;

  localparam logic [HOUR_W-1:0] KF_HOUR [KF_MAX] = '{
    21'd0, 21'd262144, 21'd393216, 21'd786432, 21'd1179648, 21'd1441792,
    21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0, 21'd0
  };

  localparam logic [COLOR_W-1:0] KF_COLOR [KF_MAX][CHAN_COUNT] = '{
    '{16'd1311,  16'd1966,  16'd6554,  16'd1966,  16'd2621,  16'd6554},
    '{16'd5243,  16'd3932,  16'd11796, 16'd6554,  16'd4588,  16'd7864},
    '{16'd62259, 16'd36045, 16'd16384, 16'd36045, 16'd19661, 16'd13107},
    '{16'd26214, 16'd42598, 16'd62259, 16'd62259, 16'd62259, 16'd62259},
    '{16'd42598, 16'd16384, 16'd29491, 16'd58982, 16'd36045, 16'd16384},
    '{16'd1311,  16'd1966,  16'd6554,  16'd1966,  16'd2621,  16'd6554},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  // Sine table generation (elaboration only)
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // sin(x) for x in Q30, Taylor series through x^15, rounded to Q1.15 and saturated.
  function automatic logic [SINE_W-1:0] sine_q15(input longint unsigned x);
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    int              n;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / TAYLOR_DIV[n];
      if ((n & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

  // Controller to datapath
  typedef struct packed {
    logic              load;       // take a word into the accumulator
    logic              reduce;     // one wrap step on the accumulator
    logic              commit;     // accumulator becomes the hour
    logic              search;     // pick segment, start divider and phase
    logic              div_step;   // one fraction bit
    logic              mix_valid;  // multiply one colour channel
    logic [CHAN_W-1:0] chan;
    logic              out_load;   // fill the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic acc_ok;                  // accumulator already in [0, 24h)
  } status_t;

  typedef struct packed {
    logic [HOUR_W-1:0]                   current_hour;
    logic [CHAN_COUNT-1:0][COLOR_W-1:0]  colour;
    logic signed [SUN_W-1:0]             sun_x;
    logic signed [SUN_W-1:0]             sun_y;
  } result_t;

endpackage

[rtl/tdkc_channels.sv]
// Valid/ready channel interfaces for the input and result words.
interface tdkc_item_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic signed [tdkc_pkg::TIME_W-1:0] time_value;

  modport source (output valid, output mode, output time_value, input ready);
  modport sink   (input valid, input mode, input time_value, output ready);
endinterface

interface tdkc_result_if;
  logic                                valid;
  logic                                ready;
  logic        [tdkc_pkg::HOUR_W-1:0]  current_hour;
  logic        [tdkc_pkg::COLOR_W-1:0] sky_red;
  logic        [tdkc_pkg::COLOR_W-1:0] sky_green;
  logic        [tdkc_pkg::COLOR_W-1:0] sky_blue;
  logic        [tdkc_pkg::COLOR_W-1:0] ambient_red;
  logic        [tdkc_pkg::COLOR_W-1:0] ambient_green;
  logic        [tdkc_pkg::COLOR_W-1:0] ambient_blue;
  logic signed [tdkc_pkg::SUN_W-1:0]   sun_x;
  logic signed [tdkc_pkg::SUN_W-1:0]   sun_y;

  modport source (output valid, output current_hour, output sky_red, output sky_green,
                  output sky_blue, output ambient_red, output ambient_green,
                  output ambient_blue, output sun_x, output sun_y, input ready);
  modport sink   (input valid, input current_hour, input sky_red, input sky_green,
                  input sky_blue, input ambient_red, input ambient_green,
                  input ambient_blue, input sun_x, input sun_y, output ready);
endinterface

[rtl/time_of_day_keyframe_color_core.sv]
// Time-of-day core: keeps a wrapping Q5.16 hour and, per input word, returns the
// hour, keyframe-interpolated sky and ambient colours and a sun direction vector.
// One input word is taken at a time; a word occupies the block from acceptance until
// its result is loaded into the output register and the next word can be accepted.
// That time is set by the wrap loop (one 24h add or subtract per cycle, up to six for
// the widest set or advance values), a 16-step serial divider that forms the
// interpolation fraction, and a single shared multiplier that mixes the six colour
// channels one per cycle. The result sits in an output register, so a finished
// word may wait for the sink while the next input word is already in work; only
// the final load stalls if the previous word has not yet been taken.
module time_of_day_keyframe_color_core #(
  parameter int SINE_TABLE_DEPTH = tdkc_pkg::SINE_TABLE_DEPTH_DEF,  // quarter-wave entries
  parameter int KEYFRAME_COUNT   = tdkc_pkg::KEYFRAME_COUNT_DEF     // clamped to 2..16
) (
  input  logic           clk,
  input  logic           rst,
  tdkc_item_if.sink      item,
  tdkc_result_if.source  result
);

  tdkc_pkg::cmd_t    cmd;
  tdkc_pkg::status_t status;
  tdkc_pkg::result_t word;

  // Controller: owns the handshake, the sequencing and the output valid bit.
  tdkc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: hour register, wrap accumulator, segment search, divider,
  // colour multiplier, sine lookup pipeline and the result payload register.
  tdkc_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .KEYFRAME_COUNT   (KEYFRAME_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (item.mode),
    .time_value (item.time_value),
    .status     (status),
    .word       (word)
  );

  // Payload fan-out; colour channels are sky r,g,b then ambient r,g,b.
  assign result.current_hour  = word.current_hour;
  assign result.sky_red       = word.colour[0];
  assign result.sky_green     = word.colour[1];
  assign result.sky_blue      = word.colour[2];
  assign result.ambient_red   = word.colour[3];
  assign result.ambient_green = word.colour[4];
  assign result.ambient_blue  = word.colour[5];
  assign result.sun_x         = word.sun_x;
  assign result.sun_y         = word.sun_y;

`ifndef SYNTH
  // The output register is only refilled once the previous word has gone.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result.valid || result.ready))
    else $error("output word overwritten before it was taken");

  // One word in work at a time: acceptance closes the input side.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("input accepted while a word is in work");

  // Any delivered hour has been wrapped into a single day.
  a_hour_wrapped: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.current_hour < tdkc_pkg::DAY_Q16))
    else $error("delivered hour outside one day");

  // The hour only moves once the accumulator has been wrapped.
  a_commit_wrapped: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.acc_ok)
    else $error("hour committed before wrap finished");
`endif

endmodule

[rtl/tdkc_div.sv]
// Restoring serial divider giving the Q0.16 segment fraction, one bit per step.
module tdkc_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [tdkc_pkg::HOUR_W-1:0]   dividend,
  input  logic [tdkc_pkg::HOUR_W-1:0]   divisor,
  output logic [tdkc_pkg::FRAC_W-1:0]   quotient
);

  logic [tdkc_pkg::HOUR_W-1:0] rem;
  logic [tdkc_pkg::HOUR_W-1:0] den;
  logic [tdkc_pkg::HOUR_W:0]   rem_dbl;
  logic                        fits;

  // dividend < divisor on entry, so remainder stays below divisor
  assign rem_dbl = {rem, 1'b0};
  assign fits    = rem_dbl >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (load) begin
      rem      <= dividend;
      den      <= divisor;
      quotient <= '0;
    end else if (step) begin
      rem      <= fits ? tdkc_pkg::HOUR_W'(rem_dbl - {1'b0, den})
                       : tdkc_pkg::HOUR_W'(rem_dbl);
      quotient <= {quotient[tdkc_pkg::FRAC_W-2:0], fits};
    end
  end

endmodule

[rtl/tdkc_dp.sv]
// Datapath: hour wrap, segment search, colour mixing, sun phase pipeline and output register.
module tdkc_dp #(
  parameter int SINE_TABLE_DEPTH = tdkc_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int KEYFRAME_COUNT   = tdkc_pkg::KEYFRAME_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tdkc_pkg::cmd_t                    cmd,
  input  logic                              mode,
  input  logic signed [tdkc_pkg::TIME_W-1:0] time_value,
  output tdkc_pkg::status_t                 status,
  output tdkc_pkg::result_t                 word
);

  localparam int KF_N  = (KEYFRAME_COUNT < 2) ? 2 :
                         (KEYFRAME_COUNT > tdkc_pkg::KF_MAX) ? tdkc_pkg::KF_MAX :
                         KEYFRAME_COUNT;
  localparam int TW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam longint unsigned PD_MAX = 64'd393216 * 64'(SINE_TABLE_DEPTH);
  localparam int PD_W  = $clog2(PD_MAX);
  localparam int Y_W   = PD_W - tdkc_pkg::QUARTER_SHIFT;
  localparam int RQ_W  = Y_W + 15;
  localparam int HW    = tdkc_pkg::HOUR_W;
  localparam int AW    = tdkc_pkg::ACC_W;
  localparam int CW    = tdkc_pkg::COLOR_W;

  // ---------------- hour and wrap ----------------
  logic        [HW-1:0] hour_now;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] v_ext;
  logic signed [AW-1:0] adv_ext;

  assign v_ext   = AW'(time_value);
  assign adv_ext = time_value[tdkc_pkg::TIME_W-1] ? '0 : v_ext;
  assign status.acc_ok = !acc[AW-1] && (acc[AW-2:0] < (AW-1)'(tdkc_pkg::DAY_Q16));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= mode ? ($signed({{(AW-HW){1'b0}}, hour_now}) + adv_ext) : v_ext;
    end else if (cmd.reduce) begin
      if (acc[AW-1]) begin
        acc <= acc + $signed({{(AW-HW){1'b0}}, tdkc_pkg::DAY_Q16});
      end else begin
        acc <= acc - $signed({{(AW-HW){1'b0}}, tdkc_pkg::DAY_Q16});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hour_now <= '0;
    end else if (cmd.commit) begin
      hour_now <= acc[HW-1:0];
    end
  end

  // ---------------- segment search ----------------
  logic [tdkc_pkg::KF_IDX_W-1:0] seg_a_c, seg_b_c, seg_a, seg_b;
  logic [HW-1:0]                 diff_c, span_c;
  logic                          found;

  always_comb begin
    seg_a_c = tdkc_pkg::KF_IDX_W'(KF_N - 1);
    seg_b_c = '0;
    diff_c  = '0;
    span_c  = HW'(1);
    found   = 1'b0;
    if (hour_now >= tdkc_pkg::KF_HOUR[KF_N-1]) begin
      span_c = tdkc_pkg::DAY_Q16 - tdkc_pkg::KF_HOUR[KF_N-1];
      diff_c = hour_now - tdkc_pkg::KF_HOUR[KF_N-1];
      found  = 1'b1;
    end
    for (int i = 0; i < KF_N - 1; i++) begin
      if (!found && hour_now < tdkc_pkg::KF_HOUR[i+1]) begin
        seg_a_c = tdkc_pkg::KF_IDX_W'(i);
        seg_b_c = tdkc_pkg::KF_IDX_W'(i + 1);
        found   = 1'b1;
        // descending or empty segments leave the fraction at zero
        if (tdkc_pkg::KF_HOUR[i+1] > tdkc_pkg::KF_HOUR[i] &&
            hour_now >= tdkc_pkg::KF_HOUR[i]) begin
          span_c = tdkc_pkg::KF_HOUR[i+1] - tdkc_pkg::KF_HOUR[i];
          diff_c = hour_now - tdkc_pkg::KF_HOUR[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      seg_a <= seg_a_c;
      seg_b <= seg_b_c;
    end
  end

  logic [tdkc_pkg::FRAC_W-1:0] frac;

  tdkc_div u_div (
    .clk      (clk),
    .load     (cmd.search),
    .step     (cmd.div_step),
    .dividend (diff_c),
    .divisor  (span_c),
    .quotient (frac)
  );

  // ---------------- colour mix, one channel per cycle ----------------
  logic        [CW-1:0]              col_a, col_b, base;
  logic signed [CW:0]                delta;
  logic signed [2*CW+1:0]            prod, prod_round;
  logic signed [CW+1:0]              step_c;
  logic        [CW+1:0]              mixed;
  logic        [tdkc_pkg::CHAN_W-1:0] prod_chan;
  logic                              prod_valid;
  logic [tdkc_pkg::CHAN_COUNT-1:0][CW-1:0] colour;

  assign col_a      = tdkc_pkg::KF_COLOR[seg_a][cmd.chan];
  assign col_b      = tdkc_pkg::KF_COLOR[seg_b][cmd.chan];
  assign delta      = $signed({1'b0, col_b}) - $signed({1'b0, col_a});
  assign prod_round = prod + $signed((2*CW+2)'(32768));
  assign step_c     = prod_round[2*CW+1:CW];
  assign mixed      = $unsigned($signed({2'b00, base}) + step_c);

  always_ff @(posedge clk) begin
    if (cmd.mix_valid) begin
      prod      <= delta * $signed({1'b0, frac});
      base      <= col_a;
      prod_chan <= cmd.chan;
    end
    if (prod_valid) begin
      colour[prod_chan] <= mixed[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cmd.mix_valid;
    end
  end

  // ---------------- sun phase ----------------
  logic [HW:0]                      ph_sum;
  logic [HW-1:0]                    ph;
  logic [1:0]                       quad_c, quad_r;
  logic [tdkc_pkg::QUARTER_W-1:0]   rem_c, rem_r;
  logic [PD_W-1:0]                  rem_d;
  logic [RQ_W-1:0]                  rq;
  logic [TW-1:0]                    idx;
  logic [tdkc_pkg::SINE_W-1:0]      s_lo, s_hi;
  logic [tdkc_pkg::SINE_W-1:0]      sine_rom [0:SINE_TABLE_DEPTH];

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam longint unsigned ANGLE =
      (64'(k) * tdkc_pkg::PI_Q30) / (64'd2 * 64'(SINE_TABLE_DEPTH));
    assign sine_rom[k] = tdkc_pkg::sine_q15(ANGLE);
  end

  assign ph_sum = {1'b0, hour_now} + {1'b0, tdkc_pkg::SHIFT_Q16};

  always_comb begin
    if (ph < HW'(tdkc_pkg::QUARTER_Q16)) begin
      quad_c = 2'd0;
      rem_c  = ph[tdkc_pkg::QUARTER_W-1:0];
    end else if (ph < HW'(2 * tdkc_pkg::QUARTER_Q16)) begin
      quad_c = 2'd1;
      rem_c  = tdkc_pkg::QUARTER_W'(ph - HW'(tdkc_pkg::QUARTER_Q16));
    end else if (ph < HW'(3 * tdkc_pkg::QUARTER_Q16)) begin
      quad_c = 2'd2;
      rem_c  = tdkc_pkg::QUARTER_W'(ph - HW'(2 * tdkc_pkg::QUARTER_Q16));
    end else begin
      quad_c = 2'd3;
      rem_c  = tdkc_pkg::QUARTER_W'(ph - HW'(3 * tdkc_pkg::QUARTER_Q16));
    end
  end

  assign idx = rq[tdkc_pkg::RECIP3_SHIFT +: TW];

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      ph <= (ph_sum >= {1'b0, tdkc_pkg::DAY_Q16}) ? HW'(ph_sum - {1'b0, tdkc_pkg::DAY_Q16})
                                                  : ph_sum[HW-1:0];
    end
    // free-running; quadrant, scaled remainder, index product and table registers settle in turn after the phase loads
    quad_r <= quad_c;
    rem_r  <= rem_c;
    rem_d  <= PD_W'(rem_r) * PD_W'(SINE_TABLE_DEPTH);
    rq     <= RQ_W'(rem_d[PD_W-1:tdkc_pkg::QUARTER_SHIFT]) * RQ_W'(tdkc_pkg::RECIP3);
    s_lo   <= sine_rom[idx];
    s_hi   <= sine_rom[TW'(SINE_TABLE_DEPTH) - idx];
  end

  // ---------------- output register ----------------
  logic signed [tdkc_pkg::SUN_W-1:0] lo_pos, hi_pos, sx_c, sy_c;

  assign lo_pos = $signed({1'b0, s_lo});
  assign hi_pos = $signed({1'b0, s_hi});

  always_comb begin
    case (quad_r)
      2'd0: begin
        sx_c = hi_pos;
        sy_c = lo_pos;
      end
      2'd1: begin
        sx_c = -lo_pos;
        sy_c = hi_pos;
      end
      2'd2: begin
        sx_c = -hi_pos;
        sy_c = -lo_pos;
      end
      default: begin
        sx_c = lo_pos;
        sy_c = -hi_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      word.current_hour <= hour_now;
      word.colour       <= colour;
      word.sun_x        <= sx_c;
      word.sun_y        <= sy_c;
    end
  end

endmodule

[rtl/tdkc_ctrl.sv]
// Controller state machine sequencing wrap, search, divide, mix and output.
module tdkc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  tdkc_pkg::status_t status,
  output tdkc_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_DIVIDE = 3'd3;
  localparam logic [2:0] S_MIX    = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  localparam int CNT_W = $clog2(tdkc_pkg::FRAC_W);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(tdkc_pkg::FRAC_W - 1);
  localparam logic [CNT_W-1:0] MIX_END  = CNT_W'(tdkc_pkg::CHAN_COUNT);

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             valid_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    valid_next = result_valid && !result_ready;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load   = 1'b1;
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.acc_ok) begin
          cmd.commit = 1'b1;
          state_next = S_SEARCH;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        cnt_next   = '0;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_MIX;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_MIX: begin
        // last count only drains the product register
        if (cnt < MIX_END) begin
          cmd.mix_valid = 1'b1;
          cmd.chan      = cnt[tdkc_pkg::CHAN_W-1:0];
          cnt_next      = cnt + 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!result_valid || result_ready) begin
          cmd.out_load = 1'b1;
          valid_next   = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      result_valid <= valid_next;
    end
  end

endmodule
